>>> rtl/core/mixed_fraction_alu_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the mixed fraction ALU
// Implication helpers clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef MIXED_FRACTION_ALU_ASSERT_SVH
`define MIXED_FRACTION_ALU_ASSERT_SVH

// Same-cycle implication.
`define MFALU_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mixed fraction ALU assertion failed");

// Next-cycle implication.
`define MFALU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mixed fraction ALU assertion failed");

`endif

>>> rtl/core/mfalu_pkg.sv
// ----------------------------------------------------------------------------
// mfalu_pkg
// Shared types, codes and the microcode store of the mixed fraction ALU.
// ----------------------------------------------------------------------------
package mfalu_pkg;

  localparam int WORD_WIDTH_DEFAULT = 32;
  localparam int PC_W = 7;

  typedef logic [PC_W-1:0] pc_t;
  typedef logic [3:0] uop_t;
  typedef logic [3:0] src_t;
  typedef logic [2:0] dst_t;
  typedef logic [2:0] opcode_t;

  localparam opcode_t OP_ADD     = 3'd0;
  localparam opcode_t OP_SUB     = 3'd1;
  localparam opcode_t OP_MUL     = 3'd2;
  localparam opcode_t OP_DIV     = 3'd3;
  localparam opcode_t OP_LESS    = 3'd4;
  localparam opcode_t OP_GREATER = 3'd5;
  localparam opcode_t OP_EQUAL   = 3'd6;
  localparam opcode_t OP_REDUCE  = 3'd7;

  localparam uop_t U_END    = 4'd0;
  localparam uop_t U_ADD    = 4'd1;
  localparam uop_t U_SUB    = 4'd2;
  localparam uop_t U_MUL    = 4'd3;
  localparam uop_t U_DIV    = 4'd4;
  localparam uop_t U_LT     = 4'd5;
  localparam uop_t U_EQ     = 4'd6;
  localparam uop_t U_SETBAD = 4'd7;
  localparam uop_t U_BZ     = 4'd8;
  localparam uop_t U_BNZ    = 4'd9;
  localparam uop_t U_BLT    = 4'd10;
  localparam uop_t U_JMP    = 4'd11;

  localparam src_t S_LI   = 4'd0;
  localparam src_t S_LN   = 4'd1;
  localparam src_t S_LD   = 4'd2;
  localparam src_t S_RI   = 4'd3;
  localparam src_t S_RN   = 4'd4;
  localparam src_t S_RD   = 4'd5;
  localparam src_t S_T0   = 4'd6;
  localparam src_t S_T1   = 4'd7;
  localparam src_t S_T2   = 4'd8;
  localparam src_t S_T3   = 4'd9;
  localparam src_t S_Q    = 4'd10;
  localparam src_t S_R    = 4'd11;
  localparam src_t S_ZERO = 4'd12;
  localparam src_t S_ONE  = 4'd13;

  localparam dst_t D_T0   = 3'd0;
  localparam dst_t D_T1   = 3'd1;
  localparam dst_t D_T2   = 3'd2;
  localparam dst_t D_T3   = 3'd3;
  localparam dst_t D_OINT = 3'd4;
  localparam dst_t D_ONUM = 3'd5;
  localparam dst_t D_ODEN = 3'd6;
  localparam dst_t D_NONE = 3'd7;

  localparam pc_t ENT_NORM    = 7'd0;
  localparam pc_t ENT_ADD     = 7'd5;
  localparam pc_t ADD_BAD     = 7'd11;
  localparam pc_t ENT_SUB     = 7'd15;
  localparam pc_t ENT_MUL     = 7'd22;
  localparam pc_t ENT_DIV     = 7'd32;
  localparam pc_t ENT_LESS    = 7'd42;
  localparam pc_t ENT_GREATER = 7'd50;
  localparam pc_t ENT_EQUAL   = 7'd58;
  localparam pc_t ENT_REDUCE  = 7'd66;
  localparam pc_t RED_SWAP    = 7'd73;
  localparam pc_t RED_TEST    = 7'd75;
  localparam pc_t RED_LOOP    = 7'd76;
  localparam pc_t RED_END     = 7'd84;

  typedef struct packed {
    uop_t uop;
    src_t a;
    src_t b;
    dst_t dst;
    pc_t  target;
  } ucode_t;

  typedef struct packed {
    logic   load;
    logic   issue;
    ucode_t word;
  } dp_ctrl_t;

  typedef struct packed {
    logic done;
    logic a_zero;
    logic a_lt_b;
  } dp_stat_t;

  function automatic ucode_t mk(input uop_t uop, input src_t a, input src_t b,
                                input dst_t dst, input pc_t target);
    ucode_t u;
    u.uop = uop;
    u.a = a;
    u.b = b;
    u.dst = dst;
    u.target = target;
    return u;
  endfunction

  function automatic pc_t entry(input opcode_t op);
    pc_t p;
    unique case (op)
      OP_ADD:     p = ENT_ADD;
      OP_SUB:     p = ENT_SUB;
      OP_MUL:     p = ENT_MUL;
      OP_DIV:     p = ENT_DIV;
      OP_LESS:    p = ENT_LESS;
      OP_GREATER: p = ENT_GREATER;
      OP_EQUAL:   p = ENT_EQUAL;
      default:    p = ENT_REDUCE;
    endcase
    return p;
  endfunction

  function automatic ucode_t ucode(input pc_t pc);
    ucode_t u;
    u = mk(U_END, S_ZERO, S_ZERO, D_NONE, ENT_NORM);
    unique case (pc)
      7'd0:  u = mk(U_DIV, S_T1, S_T2, D_NONE, ENT_NORM);
      7'd1:  u = mk(U_ADD, S_T0, S_Q, D_OINT, ENT_NORM);
      7'd2:  u = mk(U_ADD, S_R, S_ZERO, D_ONUM, ENT_NORM);
      7'd3:  u = mk(U_ADD, S_T2, S_ZERO, D_ODEN, ENT_NORM);
      7'd5:  u = mk(U_MUL, S_LN, S_RD, D_T0, ENT_NORM);
      7'd6:  u = mk(U_MUL, S_RN, S_LD, D_T1, ENT_NORM);
      7'd7:  u = mk(U_ADD, S_T0, S_T1, D_T1, ENT_NORM);
      7'd8:  u = mk(U_MUL, S_LD, S_RD, D_T2, ENT_NORM);
      7'd9:  u = mk(U_ADD, S_LI, S_RI, D_T0, ENT_NORM);
      7'd10: u = mk(U_BNZ, S_T2, S_ZERO, D_NONE, ENT_NORM);
      7'd11: u = mk(U_SETBAD, S_ZERO, S_ZERO, D_NONE, ENT_NORM);
      7'd12: u = mk(U_ADD, S_T0, S_ZERO, D_OINT, ENT_NORM);
      7'd13: u = mk(U_ADD, S_T1, S_ZERO, D_ONUM, ENT_NORM);
      7'd15: u = mk(U_MUL, S_LN, S_RD, D_T0, ENT_NORM);
      7'd16: u = mk(U_MUL, S_RN, S_LD, D_T1, ENT_NORM);
      7'd17: u = mk(U_SUB, S_T0, S_T1, D_T1, ENT_NORM);
      7'd18: u = mk(U_MUL, S_LD, S_RD, D_T2, ENT_NORM);
      7'd19: u = mk(U_SUB, S_LI, S_RI, D_T0, ENT_NORM);
      7'd20: u = mk(U_BNZ, S_T2, S_ZERO, D_NONE, ENT_NORM);
      7'd21: u = mk(U_JMP, S_ZERO, S_ZERO, D_NONE, ADD_BAD);
      7'd22: u = mk(U_MUL, S_LI, S_LD, D_T0, ENT_NORM);
      7'd23: u = mk(U_ADD, S_T0, S_LN, D_T0, ENT_NORM);
      7'd24: u = mk(U_MUL, S_RI, S_RD, D_T1, ENT_NORM);
      7'd25: u = mk(U_ADD, S_T1, S_RN, D_T1, ENT_NORM);
      7'd26: u = mk(U_MUL, S_T0, S_T1, D_T1, ENT_NORM);
      7'd27: u = mk(U_MUL, S_LD, S_RD, D_T2, ENT_NORM);
      7'd28: u = mk(U_ADD, S_ZERO, S_ZERO, D_T0, ENT_NORM);
      7'd29: u = mk(U_BNZ, S_T2, S_ZERO, D_NONE, ENT_NORM);
      7'd30: u = mk(U_ADD, S_ONE, S_ZERO, D_T2, ENT_NORM);
      7'd31: u = mk(U_JMP, S_ZERO, S_ZERO, D_NONE, ENT_NORM);
      7'd32: u = mk(U_MUL, S_LI, S_LD, D_T0, ENT_NORM);
      7'd33: u = mk(U_ADD, S_T0, S_LN, D_T0, ENT_NORM);
      7'd34: u = mk(U_MUL, S_RI, S_RD, D_T1, ENT_NORM);
      7'd35: u = mk(U_ADD, S_T1, S_RN, D_T1, ENT_NORM);
      7'd36: u = mk(U_MUL, S_LD, S_T1, D_T2, ENT_NORM);
      7'd37: u = mk(U_MUL, S_T0, S_RD, D_T1, ENT_NORM);
      7'd38: u = mk(U_ADD, S_ZERO, S_ZERO, D_T0, ENT_NORM);
      7'd39: u = mk(U_BNZ, S_T2, S_ZERO, D_NONE, ENT_NORM);
      7'd40: u = mk(U_ADD, S_ONE, S_ZERO, D_T2, ENT_NORM);
      7'd41: u = mk(U_JMP, S_ZERO, S_ZERO, D_NONE, ENT_NORM);
      7'd42: u = mk(U_MUL, S_LI, S_LD, D_T0, ENT_NORM);
      7'd43: u = mk(U_ADD, S_T0, S_LN, D_T0, ENT_NORM);
      7'd44: u = mk(U_MUL, S_RI, S_RD, D_T1, ENT_NORM);
      7'd45: u = mk(U_ADD, S_T1, S_RN, D_T1, ENT_NORM);
      7'd46: u = mk(U_MUL, S_T0, S_RD, D_T2, ENT_NORM);
      7'd47: u = mk(U_MUL, S_T1, S_LD, D_T3, ENT_NORM);
      7'd48: u = mk(U_LT, S_T2, S_T3, D_NONE, ENT_NORM);
      7'd50: u = mk(U_MUL, S_LI, S_LD, D_T0, ENT_NORM);
      7'd51: u = mk(U_ADD, S_T0, S_LN, D_T0, ENT_NORM);
      7'd52: u = mk(U_MUL, S_RI, S_RD, D_T1, ENT_NORM);
      7'd53: u = mk(U_ADD, S_T1, S_RN, D_T1, ENT_NORM);
      7'd54: u = mk(U_MUL, S_T0, S_RD, D_T2, ENT_NORM);
      7'd55: u = mk(U_MUL, S_T1, S_LD, D_T3, ENT_NORM);
      7'd56: u = mk(U_LT, S_T3, S_T2, D_NONE, ENT_NORM);
      7'd58: u = mk(U_MUL, S_LI, S_LD, D_T0, ENT_NORM);
      7'd59: u = mk(U_ADD, S_T0, S_LN, D_T0, ENT_NORM);
      7'd60: u = mk(U_MUL, S_RI, S_RD, D_T1, ENT_NORM);
      7'd61: u = mk(U_ADD, S_T1, S_RN, D_T1, ENT_NORM);
      7'd62: u = mk(U_MUL, S_T0, S_RD, D_T2, ENT_NORM);
      7'd63: u = mk(U_MUL, S_T1, S_LD, D_T3, ENT_NORM);
      7'd64: u = mk(U_EQ, S_T2, S_T3, D_NONE, ENT_NORM);
      7'd66: u = mk(U_ADD, S_LI, S_ZERO, D_OINT, ENT_NORM);
      7'd67: u = mk(U_ADD, S_LN, S_ZERO, D_ONUM, ENT_NORM);
      7'd68: u = mk(U_ADD, S_LD, S_ZERO, D_ODEN, ENT_NORM);
      7'd69: u = mk(U_BLT, S_LD, S_LN, D_NONE, RED_SWAP);
      7'd70: u = mk(U_ADD, S_LD, S_ZERO, D_T0, ENT_NORM);
      7'd71: u = mk(U_ADD, S_LN, S_ZERO, D_T1, ENT_NORM);
      7'd72: u = mk(U_JMP, S_ZERO, S_ZERO, D_NONE, RED_TEST);
      7'd73: u = mk(U_ADD, S_LN, S_ZERO, D_T0, ENT_NORM);
      7'd74: u = mk(U_ADD, S_LD, S_ZERO, D_T1, ENT_NORM);
      7'd75: u = mk(U_BZ, S_T1, S_ZERO, D_NONE, RED_END);
      7'd76: u = mk(U_DIV, S_T0, S_T1, D_NONE, ENT_NORM);
      7'd77: u = mk(U_ADD, S_T1, S_ZERO, D_T0, ENT_NORM);
      7'd78: u = mk(U_ADD, S_R, S_ZERO, D_T1, ENT_NORM);
      7'd79: u = mk(U_BNZ, S_R, S_ZERO, D_NONE, RED_LOOP);
      7'd80: u = mk(U_DIV, S_LN, S_T0, D_NONE, ENT_NORM);
      7'd81: u = mk(U_ADD, S_Q, S_ZERO, D_ONUM, ENT_NORM);
      7'd82: u = mk(U_DIV, S_LD, S_T0, D_NONE, ENT_NORM);
      7'd83: u = mk(U_ADD, S_Q, S_ZERO, D_ODEN, ENT_NORM);
      default: u = mk(U_END, S_ZERO, S_ZERO, D_NONE, ENT_NORM);
    endcase
    return u;
  endfunction

endpackage

>>> rtl/core/mixed_fraction_alu.sv
// The divide is radix-2 and the multiply is a split 32x32 multiply. Add and sub skip the
// normalising divide when the denominator product is zero; reduce loops over Euclid
// remainder steps. One item is in flight at a time; the next can be taken in the cycle
// after the result leaves.
// Synchronous reset returns the sequencer to idle with no result pending.
// ----------------------------------------------------------------------------
// mixed_fraction_alu
// Arithmetic, comparison and reduction of mixed fractions, one item at a time.
// ----------------------------------------------------------------------------
module mixed_fraction_alu #(
  parameter int WORD_WIDTH = mfalu_pkg::WORD_WIDTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  operation,
  input  logic [31:0] left_integer,
  input  logic [31:0] left_numerator,
  input  logic [31:0] left_denominator,
  input  logic [31:0] right_integer,
  input  logic [31:0] right_numerator,
  input  logic [31:0] right_denominator,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] result_integer,
  output logic [31:0] result_numerator,
  output logic [31:0] result_denominator,
  output logic        compare_true,
  output logic        bad_denominator
);
  import mfalu_pkg::*;

  dp_ctrl_t ctl;
  dp_stat_t stat;

  mfalu_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .operation (operation),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ctl       (ctl),
    .stat      (stat)
  );

  mfalu_dpath #(
    .WORD_WIDTH (WORD_WIDTH)
  ) u_dpath (
    .clk                (clk),
    .rst                (rst),
    .ctl                (ctl),
    .stat               (stat),
    .left_integer       (left_integer),
    .left_numerator     (left_numerator),
    .left_denominator   (left_denominator),
    .right_integer      (right_integer),
    .right_numerator    (right_numerator),
    .right_denominator  (right_denominator),
    .result_integer     (result_integer),
    .result_numerator   (result_numerator),
    .result_denominator (result_denominator),
    .compare_true       (compare_true),
    .bad_denominator    (bad_denominator)
  );

endmodule

>>> rtl/core/mfalu_ctrl.sv
// ----------------------------------------------------------------------------
// mfalu_ctrl
// Microcoded sequencer: steps through the program of each operation.
// ----------------------------------------------------------------------------
module mfalu_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  mfalu_pkg::opcode_t  operation,
  output logic                out_valid,
  input  logic                out_ready,
  output mfalu_pkg::dp_ctrl_t ctl,
  input  mfalu_pkg::dp_stat_t stat
);
  import mfalu_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_WAIT = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  pc_t        pc;
  pc_t        pc_next;
  ucode_t     word;

  always_comb begin
    word = ucode(pc);
    state_next = state;
    pc_next = pc;
    ctl.load = 1'b0;
    ctl.issue = 1'b0;
    ctl.word = word;
    in_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.load = 1'b1;
          pc_next = entry(operation);
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        unique case (word.uop)
          U_END: begin
            state_next = ST_DONE;
          end
          U_MUL, U_DIV: begin
            ctl.issue = 1'b1;
            state_next = ST_WAIT;
          end
          U_BZ: begin
            pc_next = stat.a_zero ? word.target : pc + 1'b1;
          end
          U_BNZ: begin
            pc_next = stat.a_zero ? pc + 1'b1 : word.target;
          end
          U_BLT: begin
            pc_next = stat.a_lt_b ? word.target : pc + 1'b1;
          end
          U_JMP: begin
            pc_next = word.target;
          end
          default: begin
            ctl.issue = 1'b1;
            pc_next = pc + 1'b1;
          end
        endcase
      end
      ST_WAIT: begin
        if (stat.done) begin
          pc_next = pc + 1'b1;
          state_next = ST_RUN;
        end
      end
      default: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_next = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pc <= ENT_NORM;
    end else begin
      state <= state_next;
      pc <= pc_next;
    end
  end

endmodule

>>> rtl/core/mfalu_dpath.sv
// ----------------------------------------------------------------------------
// mfalu_dpath
// Operand and scratch registers, 64-bit adder, split multiplier, divider.
// ----------------------------------------------------------------------------
module mfalu_dpath #(
  parameter int WORD_WIDTH = mfalu_pkg::WORD_WIDTH_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  mfalu_pkg::dp_ctrl_t ctl,
  output mfalu_pkg::dp_stat_t stat,
  input  logic [31:0]         left_integer,
  input  logic [31:0]         left_numerator,
  input  logic [31:0]         left_denominator,
  input  logic [31:0]         right_integer,
  input  logic [31:0]         right_numerator,
  input  logic [31:0]         right_denominator,
  output logic [31:0]         result_integer,
  output logic [31:0]         result_numerator,
  output logic [31:0]         result_denominator,
  output logic                compare_true,
  output logic                bad_denominator
);
  import mfalu_pkg::*;

  localparam int DIV_STEPS = 64;
  localparam int CNT_W = $clog2(DIV_STEPS + 1);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS);

  function automatic logic [63:0] sext(input logic [31:0] v);
    return 64'(signed'(v[WORD_WIDTH-1:0]));
  endfunction

  function automatic logic [31:0] emit(input logic [63:0] v);
    return 32'(signed'(v[WORD_WIDTH-1:0]));
  endfunction

  function automatic logic [63:0] mag(input logic [63:0] v);
    return v[63] ? (64'd0 - v) : v;
  endfunction

  logic [63:0] li, ln, ld, ri, rn, rd;
  logic [63:0] t0, t1, t2, t3, q, r;
  logic [63:0] va, vb;

  logic [63:0] ma, mb, mprod, macc;
  logic [1:0]  mphase;
  logic        mbusy;
  logic [31:0] mx, my;
  logic [63:0] mul_p;
  logic        mul_done;

  logic [63:0]      dq, drem, dvs;
  logic [CNT_W-1:0] dcnt;
  logic             dbusy, negq, negr;
  logic [64:0]      dshift, ddiff;
  logic             div_done;

  logic        wr_en;
  logic [63:0] wr_val;

  function automatic logic [63:0] pick(input src_t s, input logic [63:0] li_v,
      input logic [63:0] ln_v, input logic [63:0] ld_v, input logic [63:0] ri_v,
      input logic [63:0] rn_v, input logic [63:0] rd_v, input logic [63:0] t0_v,
      input logic [63:0] t1_v, input logic [63:0] t2_v, input logic [63:0] t3_v,
      input logic [63:0] q_v, input logic [63:0] r_v);
    logic [63:0] v;
    unique case (s)
      S_LI:    v = li_v;
      S_LN:    v = ln_v;
      S_LD:    v = ld_v;
      S_RI:    v = ri_v;
      S_RN:    v = rn_v;
      S_RD:    v = rd_v;
      S_T0:    v = t0_v;
      S_T1:    v = t1_v;
      S_T2:    v = t2_v;
      S_T3:    v = t3_v;
      S_Q:     v = q_v;
      S_R:     v = r_v;
      S_ONE:   v = 64'd1;
      default: v = 64'd0;
    endcase
    return v;
  endfunction

  assign va = pick(ctl.word.a, li, ln, ld, ri, rn, rd, t0, t1, t2, t3, q, r);
  assign vb = pick(ctl.word.b, li, ln, ld, ri, rn, rd, t0, t1, t2, t3, q, r);

  assign mul_done = mbusy && (mphase == 2'd3);
  assign div_done = dbusy && (dcnt == CNT_LAST);

  assign stat.done = mul_done || div_done;
  assign stat.a_zero = (va == 64'd0);
  assign stat.a_lt_b = $signed(va) < $signed(vb);

  always_comb begin
    unique case (mphase)
      2'd0: begin
        mx = ma[31:0];
        my = mb[31:0];
      end
      2'd1: begin
        mx = ma[31:0];
        my = mb[63:32];
      end
      default: begin
        mx = ma[63:32];
        my = mb[31:0];
      end
    endcase
    mul_p = 64'(mx) * 64'(my);
  end

  assign dshift = {drem, dq[63]};
  assign ddiff = dshift - {1'b0, dvs};

  always_comb begin
    wr_en = 1'b0;
    wr_val = va + vb;
    if (mul_done) begin
      wr_en = 1'b1;
      wr_val = macc + {mprod[31:0], 32'd0};
    end else if (ctl.issue && ctl.word.uop == U_ADD) begin
      wr_en = 1'b1;
    end else if (ctl.issue && ctl.word.uop == U_SUB) begin
      wr_en = 1'b1;
      wr_val = va - vb;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      li <= sext(left_integer);
      ln <= sext(left_numerator);
      ld <= sext(left_denominator);
      ri <= sext(right_integer);
      rn <= sext(right_numerator);
      rd <= sext(right_denominator);
      result_integer <= 32'd0;
      result_numerator <= 32'd0;
      result_denominator <= 32'd0;
      compare_true <= 1'b0;
      bad_denominator <= 1'b0;
    end
    if (wr_en) begin
      unique case (ctl.word.dst)
        D_T0:    t0 <= wr_val;
        D_T1:    t1 <= wr_val;
        D_T2:    t2 <= wr_val;
        D_T3:    t3 <= wr_val;
        D_OINT:  result_integer <= emit(wr_val);
        D_ONUM:  result_numerator <= emit(wr_val);
        D_ODEN:  result_denominator <= emit(wr_val);
        default: ;
      endcase
    end
    if (ctl.issue && ctl.word.uop == U_LT) begin
      compare_true <= stat.a_lt_b;
    end
    if (ctl.issue && ctl.word.uop == U_EQ) begin
      compare_true <= (va == vb);
    end
    if (ctl.issue && ctl.word.uop == U_SETBAD) begin
      bad_denominator <= 1'b1;
    end
    if (ctl.issue && ctl.word.uop == U_MUL) begin
      ma <= va;
      mb <= vb;
      macc <= 64'd0;
    end else if (mbusy) begin
      mprod <= mul_p;
      if (mphase == 2'd1) begin
        macc <= macc + mprod;
      end else if (mphase == 2'd2) begin
        macc <= macc + {mprod[31:0], 32'd0};
      end
    end
    if (ctl.issue && ctl.word.uop == U_DIV) begin
      dq <= mag(va);
      dvs <= mag(vb);
      drem <= 64'd0;
      negq <= va[63] ^ vb[63];
      negr <= va[63];
    end else if (div_done) begin
      q <= negq ? (64'd0 - dq) : dq;
      r <= negr ? (64'd0 - drem) : drem;
    end else if (dbusy) begin
      if (!ddiff[64]) begin
        drem <= ddiff[63:0];
      end else begin
        drem <= dshift[63:0];
      end
      dq <= {dq[62:0], ~ddiff[64]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mbusy <= 1'b0;
      mphase <= 2'd0;
      dbusy <= 1'b0;
      dcnt <= '0;
    end else begin
      if (ctl.issue && ctl.word.uop == U_MUL) begin
        mbusy <= 1'b1;
        mphase <= 2'd0;
      end else if (mul_done) begin
        mbusy <= 1'b0;
      end else if (mbusy) begin
        mphase <= mphase + 2'd1;
      end
      if (ctl.issue && ctl.word.uop == U_DIV) begin
        dbusy <= 1'b1;
        dcnt <= '0;
      end else if (div_done) begin
        dbusy <= 1'b0;
      end else if (dbusy) begin
        dcnt <= dcnt + 1'b1;
      end
    end
  end

endmodule

>>> rtl/core/mfalu_checker.sv
// ----------------------------------------------------------------------------
// mfalu_checker
// Port-level checks of the mixed fraction ALU, bound to the top level.
// ----------------------------------------------------------------------------
`include "mixed_fraction_alu_assert.svh"

module mfalu_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] result_integer,
  input logic [31:0] result_numerator,
  input logic [31:0] result_denominator,
  input logic        compare_true,
  input logic        bad_denominator
);

  logic        results_zero;
  logic [97:0] result_payload;

  assign results_zero = (result_integer == 32'd0) && (result_numerator == 32'd0) &&
                        (result_denominator == 32'd0);
  assign result_payload = {result_integer, result_numerator, result_denominator,
                           compare_true, bad_denominator};

  `MFALU_ASSERT_NOW(a_one_item, out_valid, !in_ready)
  `MFALU_ASSERT_NEXT(a_no_early_result, in_valid && in_ready, !out_valid)
  `MFALU_ASSERT_NOW(a_compare_clean, out_valid && compare_true, results_zero && !bad_denominator)
  `MFALU_ASSERT_NOW(a_bad_den_zero, out_valid && bad_denominator, (result_denominator == 32'd0) && !compare_true)
  `MFALU_ASSERT_NEXT(a_hold_result, out_valid && !out_ready, out_valid && $stable(result_payload))

endmodule

bind mixed_fraction_alu mfalu_checker u_mfalu_checker (.*);

>>> bench/tb_mixed_fraction_alu.sv
// ----------------------------------------------------------------------------
// tb_mixed_fraction_alu
// Self-checking bench for the mixed fraction ALU. A short table of directed
// items comes first, then random items under several pacing phases. Every
// accepted result is checked against a local model of the arithmetic.
// ----------------------------------------------------------------------------
module tb_mixed_fraction_alu;
  timeunit 1ns;
  timeprecision 1ps;
  import mfalu_pkg::*;

  typedef struct packed {
    bit [31:0] whole;
    bit [31:0] num;
    bit [31:0] den;
    bit        cmp;
    bit        bad;
  } fraction_t;

  typedef struct {
    opcode_t   op;
    bit [31:0] li, ln, ld, ri, rn, rd;
    bit        typed;
    fraction_t want;
  } alu_row_t;

  localparam int RANDOM_ITEMS = 1500;
  localparam int HOLD_CYCLES  = 600;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  operation = '0;
  logic [31:0] left_integer = '0;
  logic [31:0] left_numerator = '0;
  logic [31:0] left_denominator = '0;
  logic [31:0] right_integer = '0;
  logic [31:0] right_numerator = '0;
  logic [31:0] right_denominator = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] result_integer;
  logic [31:0] result_numerator;
  logic [31:0] result_denominator;
  logic        compare_true;
  logic        bad_denominator;

  fraction_t pending_results[$];
  alu_row_t  directed_rows[$];
  int        errors = 0;
  int        results_seen = 0;
  int        pace = 0;

  mixed_fraction_alu u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .operation(operation),
    .left_integer(left_integer), .left_numerator(left_numerator),
    .left_denominator(left_denominator),
    .right_integer(right_integer), .right_numerator(right_numerator),
    .right_denominator(right_denominator),
    .out_valid(out_valid), .out_ready(out_ready),
    .result_integer(result_integer), .result_numerator(result_numerator),
    .result_denominator(result_denominator),
    .compare_true(compare_true), .bad_denominator(bad_denominator)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic bit [63:0] widen(bit [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

  function automatic bit [63:0] magnitude(bit [63:0] v);
    return v[63] ? -v : v;
  endfunction

  function automatic bit [63:0] trunc_quot(bit [63:0] a, bit [63:0] b);
    bit [63:0] q;
    q = magnitude(a) / magnitude(b);
    return (a[63] ^ b[63]) ? -q : q;
  endfunction

  function automatic bit [63:0] trunc_rem(bit [63:0] a, bit [63:0] b);
    bit [63:0] r;
    r = magnitude(a) % magnitude(b);
    return a[63] ? -r : r;
  endfunction

  function automatic fraction_t fraction_result(opcode_t op, bit [31:0] li_w,
      bit [31:0] ln_w, bit [31:0] ld_w, bit [31:0] ri_w, bit [31:0] rn_w,
      bit [31:0] rd_w);
    fraction_t r;
    bit [63:0] li, ln, ld, ri, rn, rd, limp, rimp, whole, num, den, a, b;
    bit [63:0] more, less, rest;
    li = widen(li_w); ln = widen(ln_w); ld = widen(ld_w);
    ri = widen(ri_w); rn = widen(rn_w); rd = widen(rd_w);
    limp = ln + li * ld;
    rimp = rn + ri * rd;
    r = '{default: '0};
    whole = 0;
    case (op)
      OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
        if (op == OP_ADD) begin
          whole = li + ri;
          num = ln * rd + rn * ld;
          den = ld * rd;
        end else if (op == OP_SUB) begin
          whole = li - ri;
          num = ln * rd - rn * ld;
          den = ld * rd;
        end else if (op == OP_MUL) begin
          num = limp * rimp;
          den = ld * rd;
        end else begin
          num = limp * rd;
          den = ld * rimp;
        end
        if (den == 0 && (op == OP_ADD || op == OP_SUB)) begin
          r.whole = whole[31:0];
          r.num = num[31:0];
          r.bad = 1'b1;
        end else begin
          if (den == 0) den = 1;
          a = whole + trunc_quot(num, den);
          b = trunc_rem(num, den);
          r.whole = a[31:0];
          r.num = b[31:0];
          r.den = den[31:0];
        end
      end
      OP_LESS, OP_GREATER, OP_EQUAL: begin
        a = limp * rd;
        b = rimp * ld;
        if (op == OP_LESS) r.cmp = $signed(a) < $signed(b);
        else if (op == OP_GREATER) r.cmp = $signed(b) < $signed(a);
        else r.cmp = (a == b);
      end
      default: begin
        num = ln;
        den = ld;
        if ($signed(den) < $signed(num)) begin
          more = num;
          less = den;
        end else begin
          more = den;
          less = num;
        end
        if (less != 0) begin
          do begin
            rest = trunc_rem(more, less);
            more = less;
            less = rest;
          end while (rest != 0);
          num = trunc_quot(num, more);
          den = trunc_quot(den, more);
        end
        r.whole = li_w;
        r.num = num[31:0];
        r.den = den[31:0];
      end
    endcase
    return r;
  endfunction

  task automatic add_row(opcode_t op, int li, int ln, int ld, int ri, int rn, int rd,
                         bit typed = 0, fraction_t want = '{default: '0});
    alu_row_t row;
    row.op = op;
    row.li = li; row.ln = ln; row.ld = ld;
    row.ri = ri; row.rn = rn; row.rd = rd;
    row.typed = typed;
    row.want = want;
    directed_rows.push_back(row);
  endtask

  function automatic bit [31:0] random_word(bit is_den);
    case ($urandom_range(0, 9))
      0, 1, 2:    return $urandom_range(0, 40) - 20;
      3, 4, 5:    return is_den ? $urandom_range(1, 12) : $urandom_range(0, 9);
      6:          return is_den ? -$urandom_range(1, 12) : 0;
      7:          return is_den ? ($urandom_range(0, 3) == 0 ? 0 : 7) : $urandom_range(0, 999);
      default:    return $urandom;
    endcase
  endfunction

  task automatic offer(opcode_t op, bit [31:0] li, bit [31:0] ln, bit [31:0] ld,
                       bit [31:0] ri, bit [31:0] rn, bit [31:0] rd);
    while ((pace == 1 && $urandom_range(0, 99) < 75) ||
           (pace == 3 && $urandom_range(0, 99) < 31)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    left_integer <= li; left_numerator <= ln; left_denominator <= ld;
    right_integer <= ri; right_numerator <= rn; right_denominator <= rd;
    do @(posedge clk); while (!in_ready);
  endtask

  always @(posedge clk) begin
    fraction_t want;
    if (!rst && in_valid && in_ready)
      pending_results.push_back(fraction_result(opcode_t'(operation), left_integer,
          left_numerator, left_denominator, right_integer, right_numerator,
          right_denominator));
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %h %h %h", $time, result_integer,
                 result_numerator, result_denominator);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (result_integer !== want.whole) begin
          $display("%0t: integer expected %h actual %h", $time, want.whole, result_integer);
          errors++;
        end
        if (result_numerator !== want.num) begin
          $display("%0t: numerator expected %h actual %h", $time, want.num, result_numerator);
          errors++;
        end
        if (result_denominator !== want.den) begin
          $display("%0t: denominator expected %h actual %h", $time, want.den,
                   result_denominator);
          errors++;
        end
        if (compare_true !== want.cmp) begin
          $display("%0t: compare expected %b actual %b", $time, want.cmp, compare_true);
          errors++;
        end
        if (bad_denominator !== want.bad) begin
          $display("%0t: bad denominator expected %b actual %b", $time, want.bad,
                   bad_denominator);
          errors++;
        end
      end
    end
  end

  // The receiver holds off once for a long stretch so the sender stalls.
  initial begin
    bit held;
    held = 0;
    forever begin
      @(posedge clk);
      if (!held && results_seen >= 60) begin
        held = 1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if (pace == 2) out_ready <= ($urandom_range(0, 99) >= 75);
      else if (pace == 3) out_ready <= ($urandom_range(0, 99) >= 31);
      else out_ready <= 1'b1;
    end
  end

  initial begin
    #500_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    alu_row_t row;
    fraction_t want;
    opcode_t op;
    add_row(OP_ADD, 1, 1, 2, 0, 1, 3, 1, '{32'd1, 32'd5, 32'd6, 1'b0, 1'b0});
    add_row(OP_ADD, 3, 1, 0, 4, 2, 5, 1, '{32'd7, 32'd5, 32'd0, 1'b0, 1'b1});
    add_row(OP_SUB, 3, 1, 5, 4, 2, 0, 1, '{-32'sd1, -32'sd10, 32'd0, 1'b0, 1'b1});
    add_row(OP_SUB, 2, 1, 4, 1, 1, 2);
    add_row(OP_MUL, 1, 2, 3, -2, 1, 5);
    add_row(OP_MUL, 4, 1, 0, 3, 2, 7);
    add_row(OP_DIV, 1, 1, 2, 2, 3, 4);
    add_row(OP_DIV, 5, 3, 7, 0, 0, 9);
    add_row(OP_MUL, 32'h8000_0000, 32'h8000_0000, 1, 32'h8000_0000, 0, -1);
    add_row(OP_LESS, 0, 1, 2, 0, 1, 3, 1, '{32'd0, 32'd0, 32'd0, 1'b0, 1'b0});
    add_row(OP_GREATER, 0, 1, 2, 0, 1, 3, 1, '{32'd0, 32'd0, 32'd0, 1'b1, 1'b0});
    add_row(OP_EQUAL, 0, 1, 2, 0, 2, 4, 1, '{32'd0, 32'd0, 32'd0, 1'b1, 1'b0});
    add_row(OP_LESS, 1, 1, -3, 0, 5, 7);
    add_row(OP_EQUAL, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
            32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
    add_row(OP_REDUCE, 5, 0, 7, 0, 0, 0, 1, '{32'd5, 32'd0, 32'd7, 1'b0, 1'b0});
    add_row(OP_REDUCE, 9, 6, 8, 0, 0, 0, 1, '{32'd9, 32'd3, 32'd4, 1'b0, 1'b0});
    add_row(OP_REDUCE, 2, 5, 0, 0, 0, 0, 1, '{32'd2, 32'd5, 32'd0, 1'b0, 1'b0});
    add_row(OP_REDUCE, 1, -6, 4, 0, 0, 0);
    add_row(OP_REDUCE, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 0, 0, 0);
    add_row(OP_ADD, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
            32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    add_row(OP_SUB, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
            32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    add_row(OP_DIV, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff,
            32'h7fff_ffff, 32'h8000_0000, 1);

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.typed) begin
        want = fraction_result(row.op, row.li, row.ln, row.ld, row.ri, row.rn, row.rd);
        if (want != row.want) begin
          $display("%0t: table row %0d disagrees with the local model", $time, i);
          errors++;
        end
      end
      offer(row.op, row.li, row.ln, row.ld, row.ri, row.rn, row.rd);
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      pace = (n / 300) % 4;
      op = opcode_t'($urandom_range(0, 7));
      offer(op, random_word(0), random_word(0), random_word(1),
            random_word(0), random_word(0), random_word(1));
    end
    in_valid <= 1'b0;
    pace = 0;

    wait (pending_results.size() == 0);
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/mfalu_pkg.sv
rtl/core/mfalu_ctrl.sv
rtl/core/mfalu_dpath.sv
rtl/core/mixed_fraction_alu.sv
rtl/core/mfalu_checker.sv
bench/tb_mixed_fraction_alu.sv
